// ===== rtl/xtea_pkg.sv =====
// Shared types and constants for the XTEA block cipher unit.
// No dependencies; imported by every module under rtl/.
package xtea_pkg;

	localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned APB_AW = 5;

	// register indexes on the configuration port
	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_ROUNDS = 3'd4;

	localparam logic [7:0] ROUNDS_RESET = 8'd32;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef logic [KEY_WORDS-1:0][31:0] key_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic phase_b;
	} dp_cmd_t;

endpackage

// ===== rtl/xtea_cfg_regs.sv =====
// APB-style register file: key words 0..3 and round count.
// Depends on xtea_pkg.
module xtea_cfg_regs import xtea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output key_t              key,
	output logic [7:0]        round_count
);

	key_t       key_q;
	logic [7:0] rounds_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			rounds_q <= ROUNDS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY0:   key_q[0] <= pwdata;
				REG_KEY1:   key_q[1] <= pwdata;
				REG_KEY2:   key_q[2] <= pwdata;
				REG_KEY3:   key_q[3] <= pwdata;
				REG_ROUNDS: rounds_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY0:   prdata = key_q[0];
			REG_KEY1:   prdata = key_q[1];
			REG_KEY2:   prdata = key_q[2];
			REG_KEY3:   prdata = key_q[3];
			REG_ROUNDS: prdata = {24'd0, rounds_q};
			default:    prdata = '0;
		endcase
	end

	assign key         = key_q;
	assign round_count = rounds_q;

endmodule

// ===== rtl/xtea_datapath.sv =====
// XTEA datapath: y/z halves, running sum, one half-round per step command.
// Depends on xtea_pkg.
module xtea_datapath import xtea_pkg::*; (
	input  logic        clk,
	input  dp_cmd_t     cmd_in,
	input  logic        cmd,
	input  logic [63:0] data_block,
	input  key_t        key,
	input  logic [7:0]  round_count,
	output logic [63:0] result_block
);

	logic [31:0] y_q, z_q, sum_q;
	logic        decrypt_q;

	logic        target_y;
	logic [31:0] src, dst, mix, fval, upd, sum_init;
	logic [1:0]  kidx;

	// encrypt: y then z; decrypt: z then y
	assign target_y = (decrypt_q == cmd_in.phase_b);
	assign sum_init = XTEA_DELTA * {24'd0, round_count};

	always_comb begin
		src  = target_y ? z_q : y_q;
		dst  = target_y ? y_q : z_q;
		kidx = target_y ? sum_q[1:0] : sum_q[12:11];
		mix  = ((src << 4) ^ (src >> 5)) + src;
		fval = mix ^ (sum_q + key[kidx]);
		upd  = decrypt_q ? (dst - fval) : (dst + fval);
	end

	always_ff @(posedge clk) begin
		if (cmd_in.load) begin
			y_q       <= data_block[63:32];
			z_q       <= data_block[31:0];
			decrypt_q <= cmd;
			sum_q     <= (cmd == CMD_DECRYPT) ? sum_init : 32'd0;
		end else if (cmd_in.step) begin
			if (target_y)
				y_q <= upd;
			else
				z_q <= upd;
			if (!cmd_in.phase_b)
				sum_q <= decrypt_q ? (sum_q - XTEA_DELTA) : (sum_q + XTEA_DELTA);
		end
	end

	assign result_block = {y_q, z_q};

endmodule

// ===== rtl/xtea_ctrl.sv =====
// XTEA controller: sequences half-rounds and raises busy/done.
// Depends on xtea_pkg.
module xtea_ctrl import xtea_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] round_count,
	output logic       busy,
	output logic       done,
	output dp_cmd_t    dp_cmd
);

	ctrl_state_t state_q, state_d;
	logic [7:0]  count_q;
	logic        phase_q;
	logic        accept;
	logic        last_step;

	assign accept    = start && !busy;
	assign last_step = phase_q && (count_q == 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		busy           = 1'b1;
		done           = 1'b0;
		dp_cmd.load    = 1'b0;
		dp_cmd.step    = 1'b0;
		dp_cmd.phase_b = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				dp_cmd.load = start;
				if (start)
					state_d = (round_count == 8'd0) ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				dp_cmd.step = 1'b1;
				if (last_step)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			count_q <= round_count;
			phase_q <= 1'b0;
		end else if (dp_cmd.step) begin
			phase_q <= !phase_q;
			if (phase_q)
				count_q <= count_q - 8'd1;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && last_step) |=> done)
		else $error("done missing after last half-round");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (count_q != 8'd0))
		else $error("round counter empty while running");

endmodule

// ===== rtl/xtea_block_cipher_unit.sv =====
// Top level of the XTEA block cipher unit.
// Depends on xtea_pkg, xtea_cfg_regs, xtea_ctrl, xtea_datapath.
//
// channel   direction  handshake                 payload
// input     in         start & !busy             cmd, data_block
// result    out        done (one-cycle strobe)   result_block
// config    in         psel & penable & pwrite   paddr, pwdata (prdata on read)
//
// One half-round per cycle: the round loop through the shared half-round
// adder/mixer sets the rate. busy stays high from the accept edge through
// the done strobe, so no new block is accepted while one is running.
// done pulses for one cycle with result_block valid.
// Reset is asynchronous, active low; it clears keys to 0 and rounds to 32.
// The receiver cannot stall; no result is ever held back.
module xtea_block_cipher_unit import xtea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cmd,
	input  logic [63:0]       data_block,
	output logic              busy,
	output logic              done,
	output logic [63:0]       result_block,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	key_t       key;
	logic [7:0] round_count;
	dp_cmd_t    dp_cmd;

	xtea_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.key         (key),
		.round_count (round_count)
	);

	xtea_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.round_count (round_count),
		.busy        (busy),
		.done        (done),
		.dp_cmd      (dp_cmd)
	);

	xtea_datapath u_dp (
		.clk          (clk),
		.cmd_in       (dp_cmd),
		.cmd          (cmd),
		.data_block   (data_block),
		.key          (key),
		.round_count  (round_count),
		.result_block (result_block)
	);

endmodule

// ===== tb/xtea_block_cipher_unit_test.sv =====
// Self-checking testbench for xtea_block_cipher_unit: directed and random blocks checked
// against an in-bench XTEA model, plus register access over the APB port.
// Depends on xtea_pkg and the RTL under rtl/.
module xtea_block_cipher_unit_test;
	import xtea_pkg::*;

	localparam int REG_SLOTS = 2 ** (APB_AW - 2);

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              cmd;
	logic [63:0]       data_block;
	logic              busy;
	logic              done;
	logic [63:0]       result_block;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	logic [31:0] key_shadow [KEY_WORDS];
	logic [7:0]  rounds_shadow;
	logic [63:0] pending_results [$];
	int          error_count = 0;

	xtea_block_cipher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.data_block(data_block),
		.busy(busy),
		.done(done),
		.result_block(result_block),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] mix_half(logic [31:0] h);
		return ((h << 4) ^ (h >> 5)) + h;
	endfunction

	function automatic logic [63:0] xtea_cipher(logic op, logic [63:0] blk);
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sum;
		y = blk[63:32];
		z = blk[31:0];
		if (op == CMD_ENCRYPT) begin
			sum = '0;
			for (int r = 0; r < rounds_shadow; r++) begin
				y = y + (mix_half(z) ^ (sum + key_shadow[sum[1:0]]));
				sum = sum + XTEA_DELTA;
				z = z + (mix_half(y) ^ (sum + key_shadow[sum[12:11]]));
			end
		end else begin
			sum = XTEA_DELTA * {24'd0, rounds_shadow};
			for (int r = 0; r < rounds_shadow; r++) begin
				z = z - (mix_half(y) ^ (sum + key_shadow[sum[12:11]]));
				sum = sum - XTEA_DELTA;
				y = y - (mix_half(z) ^ (sum + key_shadow[sum[1:0]]));
			end
		end
		return {y, z};
	endfunction

	function automatic logic [31:0] reg_value(int idx);
		if (idx < REG_ROUNDS)
			return key_shadow[idx];
		return {24'd0, rounds_shadow};
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return $urandom_range(0, 2);
		if (roll < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result_block %h, expected none", $time, result_block);
				error_count++;
			end else begin
				if (result_block !== pending_results[0]) begin
					$display("%0t: result_block expected %h got %h", $time,
						pending_results[0], result_block);
					error_count++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	task automatic cfg_write(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < REG_ROUNDS)
			key_shadow[idx] = value;
		else if (idx == REG_ROUNDS)
			rounds_shadow = value[7:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_check(int idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_AW'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx)) begin
			$display("%0t: register %0d expected %h got %h", $time, idx, reg_value(idx), prdata);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(logic op, logic [63:0] blk);
		start <= 1'b1;
		cmd <= op;
		data_block <= blk;
		do @(posedge clk); while (busy);
		pending_results.push_back(xtea_cipher(op, blk));
	endtask

	task automatic sender_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_keys(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2, logic [31:0] k3);
		cfg_write(REG_KEY0, k0);
		cfg_write(REG_KEY1, k1);
		cfg_write(REG_KEY2, k2);
		cfg_write(REG_KEY3, k3);
	endtask

	task automatic send_both(logic [63:0] blk);
		send_block(CMD_ENCRYPT, blk);
		send_block(CMD_DECRYPT, blk);
	endtask

	task automatic test_reset_values();
		for (int i = 0; i <= REG_ROUNDS; i++)
			cfg_check(i);
	endtask

	task automatic test_register_access();
		set_keys(32'hffff_ffff, 32'h0000_0000, 32'hdead_beef, 32'h0123_4567);
		cfg_write(REG_ROUNDS, 32'h0000_00ff);
		for (int i = 0; i <= REG_ROUNDS; i++)
			cfg_check(i);
		for (int i = REG_ROUNDS + 1; i < REG_SLOTS; i++)
			cfg_write(i, $urandom);
		for (int i = 0; i <= REG_ROUNDS; i++)
			cfg_check(i);
	endtask

	task automatic test_directed_blocks();
		set_keys(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		cfg_write(REG_ROUNDS, {24'd0, ROUNDS_RESET});
		send_both(64'h0000_0000_0000_0000);
		send_both(64'hffff_ffff_ffff_ffff);
		drain();
		set_keys(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_both(64'h8000_0000_0000_0001);
		send_both(64'ha5a5_a5a5_5a5a_5a5a);
		drain();
		set_keys(32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f);
		send_both(64'h4142_4344_4546_4748);
		drain();
	endtask

	task automatic test_zero_rounds();
		cfg_write(REG_ROUNDS, 32'd0);
		send_both(64'h0123_4567_89ab_cdef);
		send_both(64'hffff_ffff_0000_0000);
		drain();
	endtask

	task automatic test_round_extremes();
		cfg_write(REG_ROUNDS, 32'd1);
		send_both(64'hfedc_ba98_7654_3210);
		send_both(64'h0000_0000_ffff_ffff);
		drain();
		cfg_write(REG_ROUNDS, 32'd255);
		send_both(64'h5555_5555_aaaa_aaaa);
		drain();
	endtask

	task automatic random_phase(logic [7:0] rounds, int count, bit hold_mid);
		logic [31:0] k [KEY_WORDS];
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < KEY_WORDS; i++) begin
			case ($urandom_range(0, 5))
				0: k[i] = '0;
				1: k[i] = '1;
				default: k[i] = $urandom;
			endcase
		end
		set_keys(k[0], k[1], k[2], k[3]);
		cfg_write(REG_ROUNDS, {24'd0, rounds});
		cfg_check(REG_ROUNDS);
		for (int n = 0; n < count; n++) begin
			send_block(1'($urandom_range(0, 1)), {$urandom, $urandom});
			if (hold_mid && n == count / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end else if (burst_left > 0) begin
				burst_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				burst_left = $urandom_range(5, 20);
			end else begin
				sender_gap(pick_gap());
			end
		end
		drain();
	endtask

	task automatic test_random_traffic();
		random_phase(8'd1, 120, 1'b1);
		random_phase(8'd2, 100, 1'b0);
		random_phase(8'($urandom_range(3, 8)), 120, 1'b0);
		random_phase(ROUNDS_RESET, 100, 1'b1);
		random_phase(8'd0, 60, 1'b0);
		random_phase(8'($urandom_range(1, 16)), 120, 1'b0);
		random_phase(8'd255, 16, 1'b0);
		random_phase(8'($urandom_range(17, 64)), 100, 1'b0);
		random_phase(8'($urandom_range(1, 4)), 90, 1'b1);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_ENCRYPT;
		data_block <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < KEY_WORDS; i++)
			key_shadow[i] = '0;
		rounds_shadow = ROUNDS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_directed_blocks();
		test_zero_rounds();
		test_round_extremes();
		test_random_traffic();

		drain();
		repeat (2 * rounds_shadow + 8) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== xtea_block_cipher_unit.f =====
rtl/xtea_pkg.sv
rtl/xtea_cfg_regs.sv
rtl/xtea_datapath.sv
rtl/xtea_ctrl.sv
rtl/xtea_block_cipher_unit.sv
tb/xtea_block_cipher_unit_test.sv
